FILE: hdl/izhikevich_neuron_stdp_update_unit_macros.svh
// Assertion macros used by the block's top module.
`ifndef IZHIKEVICH_NEURON_STDP_UPDATE_UNIT_MACROS_SVH
`define IZHIKEVICH_NEURON_STDP_UPDATE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IZH_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IZH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/izh_pkg.sv
package izh_pkg;

	localparam int LANES              = 8;
	localparam int NEURON_COUNT_DEF   = 1024;
	localparam int MAX_SYNAPSES_DEF   = 64;
	localparam int FRACTION_BITS_DEF  = 16;

	localparam int IDX_W      = 10;
	localparam int CNT_W      = 7;
	localparam int SPK_W      = 64;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int EXC_W      = 11;
	localparam int RATE_W     = 16;
	localparam int BUMP_W     = 22;
	localparam int GAIN_W     = 16;
	localparam int CEIL_W     = 24;

	localparam logic [CFG_IDX_W-1:0] REG_EXC_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_EXC  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BUMP_EXC  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_INH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BUMP_INH  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DEP_GAIN  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_POT_GAIN  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_CEILING   = 3'd7;

	localparam logic [EXC_W-1:0]  EXC_COUNT_RST = 11'd800;
	localparam logic [RATE_W-1:0] RATE_EXC_RST  = 16'd1311;
	localparam logic [RATE_W-1:0] RATE_INH_RST  = 16'd6554;
	localparam logic [GAIN_W-1:0] DEP_GAIN_RST  = 16'd7864;
	localparam logic [GAIN_W-1:0] POT_GAIN_RST  = 16'd6554;

	typedef logic signed [31:0] q_t;

	typedef struct packed {
		logic clear;
		logic p1;
		logic p2;
		logic active;
		logic spike;
	} lane_ctl_t;

	typedef struct packed {
		logic start;
		logic clear;
		logic exc;
	} soma_cmd_t;

	typedef struct packed {
		logic done;
		logic fired;
	} soma_rsp_t;

	function automatic q_t sat32(input logic signed [63:0] x);
		if (x > 64'sd2147483647) begin
			return 32'sh7FFFFFFF;
		end else if (x < -64'sd2147483648) begin
			return 32'sh80000000;
		end
		return x[31:0];
	endfunction

endpackage

FILE: hdl/izh_lane.sv
module izh_lane #(
	parameter int ROWS          = 8192,
	parameter int ROW_W         = 13,
	parameter int FRACTION_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [ROW_W-1:0]      addr,
	input  izh_pkg::lane_ctl_t    ctl,
	input  logic                  exc,
	input  logic                  fired,
	input  izh_pkg::q_t           dep,
	input  logic [15:0]           pot_gain,
	input  logic [23:0]           ceiling,
	input  izh_pkg::q_t           clr_weight,
	output izh_pkg::q_t           contrib
);

	localparam logic signed [63:0] ONE_Q   = 64'sd1 <<< FRACTION_BITS;
	localparam logic signed [63:0] DECAY_Q = (19 * ONE_Q + 10) / 20;
	localparam logic signed [63:0] DT_Q    = (ONE_Q + 500) / 1000;

	izh_pkg::q_t wmem [ROWS];
	izh_pkg::q_t pmem [ROWS];

	izh_pkg::lane_ctl_t ctl_s1, ctl_s2, ctl_s3;
	logic [ROW_W-1:0]   addr_s1, addr_s2, addr_s3;
	izh_pkg::q_t        w_s1, pre_s1, w_s2, pot_s2, w_s3, dw_s3, contrib_s2;

	logic signed [63:0] pre_prod, pot_prod, dw_prod, w_sum;
	izh_pkg::q_t        pre_new, pot_val, term, dw_val, w_new;

	always_comb begin
		pre_prod = 64'(pre_s1) * DECAY_Q;
		pre_new  = izh_pkg::sat32(64'(izh_pkg::sat32(pre_prod >>> FRACTION_BITS))
			+ (ctl_s1.spike ? ONE_Q : 64'sd0));
		pot_prod = 64'(pre_s1) * $signed({48'd0, pot_gain});
		pot_val  = fired ? izh_pkg::q_t'(pot_prod >>> 16) : '0;
		term     = izh_pkg::sat32(64'(pot_s2) - (ctl_s2.spike ? 64'(dep) : 64'sd0));
		dw_prod  = 64'(term) * DT_Q;
		dw_val   = izh_pkg::sat32(dw_prod >>> FRACTION_BITS);
		w_sum    = 64'(w_s3) + 64'(dw_s3);
		if (w_sum < 64'sd0) begin
			w_new = '0;
		end else if (w_sum > $signed({40'd0, ceiling})) begin
			w_new = $signed({8'd0, ceiling});
		end else begin
			w_new = w_sum[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s1 <= ctl;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		w_s1       <= wmem[addr];
		pre_s1     <= pmem[addr];
		addr_s1    <= addr;
		addr_s2    <= addr_s1;
		addr_s3    <= addr_s2;
		w_s2       <= w_s1;
		w_s3       <= w_s2;
		pot_s2     <= pot_val;
		dw_s3      <= dw_val;
		contrib_s2 <= (ctl_s1.p1 && ctl_s1.active && ctl_s1.spike) ? w_s1 : '0;
		if (ctl.clear) begin
			pmem[addr] <= '0;
			wmem[addr] <= clr_weight;
		end else begin
			if (ctl_s1.p1 && ctl_s1.active && exc) begin
				pmem[addr_s1] <= pre_new;
			end
			if (ctl_s3.p2 && ctl_s3.active) begin
				wmem[addr_s3] <= w_new;
			end
		end
	end

	assign contrib = contrib_s2;

endmodule

FILE: hdl/izh_merge.sv
module izh_merge (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               clr,
	input  izh_pkg::q_t        contrib [izh_pkg::LANES],
	output logic signed [39:0] acc
);

	logic signed [39:0] acc_q;
	logic signed [39:0] lane_sum;

	// Lane results are already zero outside the current pass.
	always_comb begin
		lane_sum = '0;
		for (int l = 0; l < izh_pkg::LANES; l++) begin
			lane_sum = lane_sum + 40'(contrib[l]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (clr) begin
			acc_q <= '0;
		end else begin
			acc_q <= acc_q + lane_sum;
		end
	end

	assign acc = acc_q;

endmodule

FILE: hdl/izh_soma.sv
module izh_soma #(
	parameter int NEURON_COUNT  = 1024,
	parameter int N_W           = 10,
	parameter int FRACTION_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  izh_pkg::soma_cmd_t  cmd,
	input  logic [N_W-1:0]      addr,
	input  izh_pkg::q_t         cur,
	input  logic [15:0]         rate,
	input  logic [21:0]         bump,
	input  logic [15:0]         dep_gain,
	output izh_pkg::soma_rsp_t  rsp,
	output izh_pkg::q_t         dep
);

	localparam logic signed [63:0] ONE_Q   = 64'sd1 <<< FRACTION_BITS;
	localparam logic signed [63:0] C004_Q  = (4 * ONE_Q + 50) / 100;
	localparam logic signed [63:0] C02_Q   = (2 * ONE_Q + 5) / 10;
	localparam logic signed [63:0] DECAY_Q = (19 * ONE_Q + 10) / 20;
	localparam logic signed [63:0] FIVE_Q  = 5 * ONE_Q;
	localparam logic signed [63:0] C140_Q  = 140 * ONE_Q;
	localparam logic signed [63:0] PEAK_Q  = 30 * ONE_Q;
	localparam logic signed [63:0] VRST_Q  = -65 * ONE_Q;
	localparam logic signed [63:0] URST_Q  = -13 * ONE_Q;

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_READ = 5'd1;
	localparam logic [4:0] ST_H1   = 5'd2;
	localparam logic [4:0] ST_H2   = 5'd3;
	localparam logic [4:0] ST_H3   = 5'd4;
	localparam logic [4:0] ST_H4   = 5'd5;
	localparam logic [4:0] ST_H5   = 5'd6;
	localparam logic [4:0] ST_U1   = 5'd7;
	localparam logic [4:0] ST_U2   = 5'd8;
	localparam logic [4:0] ST_U3   = 5'd9;
	localparam logic [4:0] ST_U4   = 5'd10;
	localparam logic [4:0] ST_FIRE = 5'd11;
	localparam logic [4:0] ST_P1   = 5'd12;
	localparam logic [4:0] ST_P2   = 5'd13;
	localparam logic [4:0] ST_P3   = 5'd14;
	localparam logic [4:0] ST_P4   = 5'd15;

	izh_pkg::q_t vmem [NEURON_COUNT];
	izh_pkg::q_t umem [NEURON_COUNT];
	izh_pkg::q_t tmem [NEURON_COUNT];

	logic [4:0]         state_q;
	logic               half_q, done_q, fired_q;
	logic [N_W-1:0]     n_q;
	logic               exc_q;
	izh_pkg::q_t        v_q, u_q, post_q, k_q, d_q, s_q, dep_q;
	logic signed [63:0] prod_q, prod_sh, dep_sh;
	logic signed [32:0] ma, mb;
	logic signed [65:0] prod_full;
	izh_pkg::q_t        prod_q15, v_fin, u_fin, post_new;
	logic               spike_now;

	// One shared multiplier; every product is registered before use.
	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			ST_H1: begin
				ma = 33'(v_q);
				mb = 33'(C004_Q);
			end
			ST_H3: begin
				ma = 33'(k_q);
				mb = 33'(v_q);
			end
			ST_U1: begin
				ma = 33'(v_q);
				mb = 33'(C02_Q);
			end
			ST_U3: begin
				ma = $signed({17'd0, rate});
				mb = 33'(s_q);
			end
			ST_P1: begin
				ma = 33'(post_q);
				mb = 33'(DECAY_Q);
			end
			ST_P3: begin
				ma = $signed({17'd0, dep_gain});
				mb = 33'(post_q);
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
		prod_full = ma * mb;
		prod_sh   = prod_q >>> FRACTION_BITS;
		dep_sh    = prod_q >>> 16;
		prod_q15  = izh_pkg::sat32(prod_sh);
		spike_now = 64'(v_q) >= PEAK_Q;
		v_fin     = spike_now ? izh_pkg::q_t'(VRST_Q) : v_q;
		u_fin     = spike_now ? izh_pkg::sat32(64'(u_q) + $signed({42'd0, bump})) : u_q;
		post_new  = izh_pkg::sat32(64'(prod_q15) + (fired_q ? ONE_Q : 64'sd0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			half_q  <= 1'b0;
			done_q  <= 1'b0;
			fired_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (cmd.start) begin
					state_q <= ST_READ;
				end
				ST_READ: state_q <= ST_H1;
				ST_H1:   state_q <= ST_H2;
				ST_H2:   state_q <= ST_H3;
				ST_H3:   state_q <= ST_H4;
				ST_H4:   state_q <= ST_H5;
				ST_H5: begin
					half_q  <= !half_q;
					state_q <= half_q ? ST_U1 : ST_H1;
				end
				ST_U1:   state_q <= ST_U2;
				ST_U2:   state_q <= ST_U3;
				ST_U3:   state_q <= ST_U4;
				ST_U4:   state_q <= ST_FIRE;
				ST_FIRE: begin
					fired_q <= spike_now;
					if (exc_q) begin
						state_q <= ST_P1;
					end else begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_P1:   state_q <= ST_P2;
				ST_P2:   state_q <= ST_P3;
				ST_P3:   state_q <= ST_P4;
				ST_P4: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			vmem[addr] <= izh_pkg::q_t'(VRST_Q);
			umem[addr] <= izh_pkg::q_t'(URST_Q);
			tmem[addr] <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					n_q   <= addr;
					exc_q <= cmd.exc;
				end
				ST_READ: begin
					v_q    <= vmem[n_q];
					u_q    <= umem[n_q];
					post_q <= tmem[n_q];
				end
				ST_H1, ST_H3, ST_U1, ST_U3, ST_P1, ST_P3: prod_q <= prod_full[63:0];
				ST_H2: k_q <= izh_pkg::sat32(64'(prod_q15) + FIVE_Q);
				ST_H4: d_q <= izh_pkg::sat32(64'(prod_q15) + C140_Q - 64'(u_q) + 64'(cur));
				ST_H5: v_q <= izh_pkg::sat32(64'(v_q) + 64'(d_q >>> 1));
				ST_U2: s_q <= izh_pkg::sat32(64'(prod_q15) - 64'(u_q));
				ST_U4: u_q <= izh_pkg::sat32(64'(u_q) + dep_sh);
				ST_FIRE: begin
					v_q        <= v_fin;
					u_q        <= u_fin;
					vmem[n_q]  <= v_fin;
					umem[n_q]  <= u_fin;
				end
				ST_P2: begin
					post_q    <= post_new;
					tmem[n_q] <= post_new;
				end
				ST_P4: dep_q <= dep_sh[31:0];
				default: begin
				end
			endcase
		end
	end

	assign rsp.done  = done_q;
	assign rsp.fired = fired_q;
	assign dep       = dep_q;

endmodule

FILE: hdl/izhikevich_neuron_stdp_update_unit.sv
// Izhikevich neuron update with pair STDP, one neuron per item.
// An item is taken on a rising edge with start high and busy low: neuron_index,
// synapse_count, presyn_spikes and random_kick describe one neuron's 1 ms tick.
// Eight synapse lanes each hold a slice of the weight and presynaptic trace
// memories; a row of G = ceil(MAX_SYNAPSES/8) rows per neuron is read each cycle.
// Pass one sums the spiking weights through the merge adder and updates the
// presynaptic traces of an excitatory neuron; the soma sequencer then runs the
// two membrane half-steps, the recovery update, the spike test and, for an
// excitatory neuron, the post trace on one shared multiplier; pass two applies
// STDP to the weights of the first synapse_count synapses of an excitatory
// neuron. When NEURON_COUNT is below 1024 the index is first reduced modulo
// NEURON_COUNT. One item is in flight at a time; the next item can be taken at
// the edge that ends the result cycle. result_valid is high for exactly one
// cycle with fired_neuron and fired; the receiver cannot stall it.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user
// must do so only while busy is low, which the block itself does not enforce.
// After reset the block sweeps every memory row to its reset value, one row
// per cycle, NEURON_COUNT*G rows (8192 by default); busy stays high meanwhile.
`include "izhikevich_neuron_stdp_update_unit_macros.svh"

module izhikevich_neuron_stdp_update_unit #(
	parameter int NEURON_COUNT  = izh_pkg::NEURON_COUNT_DEF,
	parameter int MAX_SYNAPSES  = izh_pkg::MAX_SYNAPSES_DEF,
	parameter int FRACTION_BITS = izh_pkg::FRACTION_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [izh_pkg::IDX_W-1:0]         neuron_index,
	input  logic [izh_pkg::CNT_W-1:0]         synapse_count,
	input  logic [izh_pkg::SPK_W-1:0]         presyn_spikes,
	input  logic                              random_kick,
	output logic                              result_valid,
	output logic [izh_pkg::IDX_W-1:0]         fired_neuron,
	output logic                              fired,
	input  logic                              cfg_we,
	input  logic [izh_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [izh_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int LANES  = izh_pkg::LANES;
	localparam int GROUPS = (MAX_SYNAPSES + LANES - 1) / LANES;
	localparam int N_W    = $clog2(NEURON_COUNT);
	localparam int G_W    = (GROUPS > 1) ? $clog2(GROUPS) : 1;
	localparam int ROWS   = NEURON_COUNT * GROUPS;
	localparam int ROW_W  = $clog2(ROWS);
	localparam int SEQ_W  = $clog2(GROUPS + 3);
	localparam bit WRAP   = NEURON_COUNT < 1024;

	localparam logic signed [63:0] ONE_Q  = 64'sd1 <<< FRACTION_BITS;
	localparam logic signed [63:0] KICK_Q = 20 * ONE_Q;
	localparam logic signed [63:0] WEXC_Q = (54 * ONE_Q + 5) / 10;
	localparam logic signed [63:0] WINH_Q = -4 * ONE_Q;
	localparam logic [21:0] BUMP_EXC_RST = 22'(8 * ONE_Q);
	localparam logic [21:0] BUMP_INH_RST = 22'(2 * ONE_Q);
	localparam logic [23:0] CEIL_RST     = 24'(10 * ONE_Q);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_MOD   = 3'd2;
	localparam logic [2:0] ST_BASE  = 3'd3;
	localparam logic [2:0] ST_PASS1 = 3'd4;
	localparam logic [2:0] ST_SOMA  = 3'd5;
	localparam logic [2:0] ST_PASS2 = 3'd6;

	// Configuration registers.
	logic [10:0] exc_count_q;
	logic [15:0] rate_exc_q, rate_inh_q, dep_gain_q, pot_gain_q;
	logic [21:0] bump_exc_q, bump_inh_q;
	logic [23:0] ceiling_q;

	logic [2:0]             state_q;
	logic [SEQ_W-1:0]       seq_q;
	logic                   mod_step_q;
	logic [N_W-1:0]         clr_n_q;
	logic [G_W-1:0]         clr_g_q;
	logic [9:0]             idx_q, red_q;
	logic [6:0]             cnt_q;
	logic [63:0]            spk_q;
	logic                   kick_q, exc_q;
	logic [N_W-1:0]         n_q;
	logic [ROW_W-1:0]       rowbase_q;
	izh_pkg::q_t            cur_q;
	logic                   result_valid_q, fired_q;
	logic [9:0]             fired_neuron_q;

	logic [G_W-1:0]         grp;
	logic                   issue;
	logic [ROW_W-1:0]       lane_addr;
	izh_pkg::lane_ctl_t     lane_ctl [LANES];
	izh_pkg::q_t            contrib [LANES];
	izh_pkg::q_t            clr_weight, dep;
	logic signed [39:0]     acc;
	izh_pkg::soma_cmd_t     soma_cmd;
	izh_pkg::soma_rsp_t     soma_rsp;
	logic                   clr_last, pass_last;

	// Five steps of restoring reduction of the index by NEURON_COUNT.
	function automatic logic [9:0] reduce5(input logic [9:0] r, input int hi);
		logic [9:0]  t;
		logic [31:0] m;
		t = r;
		for (int i = 0; i < 5; i++) begin
			m = 32'(NEURON_COUNT) << (hi - i);
			if ({22'd0, t} >= m) begin
				t = t - m[9:0];
			end
		end
		return t;
	endfunction

	assign grp       = seq_q[G_W-1:0];
	assign issue     = seq_q < SEQ_W'(GROUPS);
	assign pass_last = seq_q == SEQ_W'(GROUPS + 2);
	assign clr_last  = (clr_n_q == N_W'(NEURON_COUNT - 1)) && (clr_g_q == G_W'(GROUPS - 1));
	assign clr_weight = (32'(clr_n_q) < 32'(izh_pkg::EXC_COUNT_RST))
		? izh_pkg::q_t'(WEXC_Q) : izh_pkg::q_t'(WINH_Q);

	always_comb begin
		if (state_q == ST_CLEAR) begin
			lane_addr = ROW_W'(ROW_W'(clr_n_q) * ROW_W'(GROUPS)) + ROW_W'(clr_g_q);
		end else begin
			lane_addr = rowbase_q + ROW_W'(grp);
		end
		for (int l = 0; l < LANES; l++) begin
			lane_ctl[l].clear  = state_q == ST_CLEAR;
			lane_ctl[l].p1     = (state_q == ST_PASS1) && issue;
			lane_ctl[l].p2     = (state_q == ST_PASS2) && issue;
			lane_ctl[l].active = (7'(grp) * 7'(LANES) + 7'(l)) < cnt_q;
			lane_ctl[l].spike  = spk_q[6'(7'(grp) * 7'(LANES) + 7'(l))];
		end
		soma_cmd.start = (state_q == ST_PASS1) && pass_last;
		soma_cmd.clear = (state_q == ST_CLEAR) && (clr_g_q == '0);
		soma_cmd.exc   = exc_q;
	end

	generate
		for (genvar l = 0; l < LANES; l++) begin : g_lane
			izh_lane #(
				.ROWS          (ROWS),
				.ROW_W         (ROW_W),
				.FRACTION_BITS (FRACTION_BITS)
			) u_lane (
				.clk        (clk),
				.arst_n     (arst_n),
				.addr       (lane_addr),
				.ctl        (lane_ctl[l]),
				.exc        (exc_q),
				.fired      (soma_rsp.fired),
				.dep        (dep),
				.pot_gain   (pot_gain_q),
				.ceiling    (ceiling_q),
				.clr_weight (clr_weight),
				.contrib    (contrib[l])
			);
		end
	endgenerate

	izh_merge u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.clr     (state_q == ST_BASE),
		.contrib (contrib),
		.acc     (acc)
	);

	izh_soma #(
		.NEURON_COUNT  (NEURON_COUNT),
		.N_W           (N_W),
		.FRACTION_BITS (FRACTION_BITS)
	) u_soma (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (soma_cmd),
		.addr     ((state_q == ST_CLEAR) ? clr_n_q : n_q),
		.cur      (cur_q),
		.rate     (exc_q ? rate_exc_q : rate_inh_q),
		.bump     (exc_q ? bump_exc_q : bump_inh_q),
		.dep_gain (dep_gain_q),
		.rsp      (soma_rsp),
		.dep      (dep)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exc_count_q <= izh_pkg::EXC_COUNT_RST;
			rate_exc_q  <= izh_pkg::RATE_EXC_RST;
			bump_exc_q  <= BUMP_EXC_RST;
			rate_inh_q  <= izh_pkg::RATE_INH_RST;
			bump_inh_q  <= BUMP_INH_RST;
			dep_gain_q  <= izh_pkg::DEP_GAIN_RST;
			pot_gain_q  <= izh_pkg::POT_GAIN_RST;
			ceiling_q   <= CEIL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				izh_pkg::REG_EXC_COUNT: exc_count_q <= cfg_data[10:0];
				izh_pkg::REG_RATE_EXC:  rate_exc_q  <= cfg_data[15:0];
				izh_pkg::REG_BUMP_EXC:  bump_exc_q  <= cfg_data[21:0];
				izh_pkg::REG_RATE_INH:  rate_inh_q  <= cfg_data[15:0];
				izh_pkg::REG_BUMP_INH:  bump_inh_q  <= cfg_data[21:0];
				izh_pkg::REG_DEP_GAIN:  dep_gain_q  <= cfg_data[15:0];
				izh_pkg::REG_POT_GAIN:  pot_gain_q  <= cfg_data[15:0];
				izh_pkg::REG_CEILING:   ceiling_q   <= cfg_data[23:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			seq_q          <= '0;
			mod_step_q     <= 1'b0;
			clr_n_q        <= '0;
			clr_g_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					if (clr_last) begin
						state_q <= ST_IDLE;
					end else if (clr_g_q == G_W'(GROUPS - 1)) begin
						clr_g_q <= '0;
						clr_n_q <= clr_n_q + 1'b1;
					end else begin
						clr_g_q <= clr_g_q + 1'b1;
					end
				end
				ST_IDLE: if (start) begin
					state_q    <= WRAP ? ST_MOD : ST_BASE;
					mod_step_q <= 1'b0;
				end
				ST_MOD: begin
					mod_step_q <= 1'b1;
					if (mod_step_q) begin
						state_q <= ST_BASE;
					end
				end
				ST_BASE: begin
					seq_q   <= '0;
					state_q <= ST_PASS1;
				end
				ST_PASS1: begin
					seq_q <= seq_q + 1'b1;
					if (pass_last) begin
						state_q <= ST_SOMA;
					end
				end
				ST_SOMA: if (soma_rsp.done) begin
					seq_q <= '0;
					if (exc_q) begin
						state_q <= ST_PASS2;
					end else begin
						result_valid_q <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end
				ST_PASS2: begin
					seq_q <= seq_q + 1'b1;
					if (pass_last) begin
						result_valid_q <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (start) begin
				idx_q  <= neuron_index;
				red_q  <= neuron_index;
				cnt_q  <= (synapse_count > 7'(MAX_SYNAPSES)) ? 7'(MAX_SYNAPSES) : synapse_count;
				spk_q  <= presyn_spikes;
				kick_q <= random_kick;
				exc_q  <= {1'b0, neuron_index} < exc_count_q;
			end
			ST_MOD: red_q <= reduce5(red_q, mod_step_q ? 4 : 9);
			ST_BASE: begin
				n_q       <= N_W'(red_q);
				rowbase_q <= ROW_W'(ROW_W'(red_q) * ROW_W'(GROUPS));
			end
			ST_PASS1: if (pass_last) begin
				cur_q <= izh_pkg::sat32(64'(acc) + (kick_q ? KICK_Q : 64'sd0));
			end
			ST_SOMA: if (soma_rsp.done) begin
				fired_q        <= soma_rsp.fired;
				fired_neuron_q <= idx_q;
			end
			default: begin
			end
		endcase
	end

	assign busy         = state_q != ST_IDLE;
	assign result_valid = result_valid_q;
	assign fired        = fired_q;
	assign fired_neuron = fired_neuron_q;

	`IZH_ASSERT_NEXT(a_strobe_single, clk, arst_n, result_valid, !result_valid, "result strobe held")
	`IZH_ASSERT_SAME(a_strobe_idle, clk, arst_n, result_valid, !busy, "result while busy")
	`IZH_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy, "item not taken")
	`IZH_ASSERT_SAME(a_soma_done, clk, arst_n, soma_rsp.done, state_q == ST_SOMA, "stray soma done")

endmodule

FILE: tb/izhikevich_neuron_stdp_update_unit_checker.sv
`timescale 1ns / 100ps

module izhikevich_neuron_stdp_update_unit_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           busy,
	input  logic [izh_pkg::IDX_W-1:0]      neuron_index,
	input  logic [izh_pkg::CNT_W-1:0]      synapse_count,
	input  logic [izh_pkg::SPK_W-1:0]      presyn_spikes,
	input  logic                           random_kick,
	input  logic                           result_valid,
	input  logic [izh_pkg::IDX_W-1:0]      fired_neuron,
	input  logic                           fired,
	input  logic                           cfg_we,
	input  logic [izh_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [izh_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             pending,
	output int                             errors
);

	localparam int     NEURONS  = 1024;
	localparam int     SYNAPSES = 64;
	localparam longint ONE      = 64'sd65536;
	localparam longint C_004    = 2621;
	localparam longint C_02     = 13107;
	localparam longint C_DECAY  = 62259;
	localparam longint C_DT     = 66;
	localparam longint W_EXC0   = 353894;

	typedef struct {
		logic [izh_pkg::IDX_W-1:0] neuron;
		logic                      spiked;
	} tick_result_t;

	tick_result_t spike_log[$];

	longint membrane_v[NEURONS];
	longint recovery_u[NEURONS];
	longint post_tr[NEURONS];
	longint pre_tr[NEURONS*SYNAPSES];
	longint syn_w[NEURONS*SYNAPSES];

	longint exc_count, rate_exc, bump_exc, rate_inh, bump_inh, dep_gain, pot_gain, w_ceiling;

	function automatic longint clamp32(longint x);
		if (x > 64'sd2147483647) begin
			return 64'sd2147483647;
		end
		if (x < -64'sd2147483648) begin
			return -64'sd2147483648;
		end
		return x;
	endfunction

	function automatic longint fxmul(longint a, longint b);
		return clamp32((a * b) >>> 16);
	endfunction

	function automatic longint soma_half(longint v, longint u, longint cur);
		longint k;
		longint dv;
		k  = clamp32(fxmul(v, C_004) + 5 * ONE);
		dv = clamp32(fxmul(k, v) + 140 * ONE - u + cur);
		return clamp32(v + (dv >>> 1));
	endfunction

	// One neuron tick: updates the stored state and returns whether it spiked.
	function automatic logic neuron_tick(logic [izh_pkg::IDX_W-1:0] idx,
			logic [izh_pkg::CNT_W-1:0] cnt_in, logic [izh_pkg::SPK_W-1:0] spk, logic kick);
		int     n;
		int     cnt;
		int     base;
		logic   exc;
		logic   spiked;
		longint cur, v, u, a, d, post, term, w;
		n    = int'(idx);
		cnt  = (int'(cnt_in) > SYNAPSES) ? SYNAPSES : int'(cnt_in);
		base = n * SYNAPSES;
		exc  = longint'(idx) < exc_count;
		cur  = 0;
		for (int j = 0; j < cnt; j++) begin
			if (spk[j]) begin
				cur += syn_w[base+j];
			end
		end
		if (kick) begin
			cur += 20 * ONE;
		end
		cur = clamp32(cur);
		if (exc) begin
			for (int j = 0; j < cnt; j++) begin
				pre_tr[base+j] = clamp32(fxmul(pre_tr[base+j], C_DECAY) + (spk[j] ? ONE : 0));
			end
		end
		a = exc ? rate_exc : rate_inh;
		d = exc ? bump_exc : bump_inh;
		v = membrane_v[n];
		u = recovery_u[n];
		v = soma_half(v, u, cur);
		v = soma_half(v, u, cur);
		u = clamp32(u + ((a * clamp32(fxmul(v, C_02) - u)) >>> 16));
		spiked = v >= 30 * ONE;
		if (spiked) begin
			v = -65 * ONE;
			u = clamp32(u + d);
		end
		membrane_v[n] = v;
		recovery_u[n] = u;
		if (exc) begin
			post = clamp32(fxmul(post_tr[n], C_DECAY) + (spiked ? ONE : 0));
			post_tr[n] = post;
			for (int j = 0; j < cnt; j++) begin
				term = 0;
				if (spiked) begin
					term += (pot_gain * pre_tr[base+j]) >>> 16;
				end
				if (spk[j]) begin
					term -= (dep_gain * post) >>> 16;
				end
				w = syn_w[base+j] + fxmul(clamp32(term), C_DT);
				if (w < 0) begin
					w = 0;
				end
				if (w > w_ceiling) begin
					w = w_ceiling;
				end
				syn_w[base+j] = w;
			end
		end
		return spiked;
	endfunction

	assign pending = spike_log.size();

	always @(posedge clk or negedge arst_n) begin
		tick_result_t exp_r;
		if (!arst_n) begin
			spike_log.delete();
			errors    = 0;
			exc_count = 800;
			rate_exc  = 1311;
			bump_exc  = 8 * ONE;
			rate_inh  = 6554;
			bump_inh  = 2 * ONE;
			dep_gain  = 7864;
			pot_gain  = 6554;
			w_ceiling = 10 * ONE;
			for (int n = 0; n < NEURONS; n++) begin
				membrane_v[n] = -65 * ONE;
				recovery_u[n] = -13 * ONE;
				post_tr[n]    = 0;
				for (int j = 0; j < SYNAPSES; j++) begin
					pre_tr[n*SYNAPSES+j] = 0;
					syn_w[n*SYNAPSES+j]  = (n < 800) ? W_EXC0 : -4 * ONE;
				end
			end
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					izh_pkg::REG_EXC_COUNT: exc_count = longint'(cfg_data[izh_pkg::EXC_W-1:0]);
					izh_pkg::REG_RATE_EXC:  rate_exc  = longint'(cfg_data[izh_pkg::RATE_W-1:0]);
					izh_pkg::REG_BUMP_EXC:  bump_exc  = longint'(cfg_data[izh_pkg::BUMP_W-1:0]);
					izh_pkg::REG_RATE_INH:  rate_inh  = longint'(cfg_data[izh_pkg::RATE_W-1:0]);
					izh_pkg::REG_BUMP_INH:  bump_inh  = longint'(cfg_data[izh_pkg::BUMP_W-1:0]);
					izh_pkg::REG_DEP_GAIN:  dep_gain  = longint'(cfg_data[izh_pkg::GAIN_W-1:0]);
					izh_pkg::REG_POT_GAIN:  pot_gain  = longint'(cfg_data[izh_pkg::GAIN_W-1:0]);
					izh_pkg::REG_CEILING:   w_ceiling = longint'(cfg_data[izh_pkg::CEIL_W-1:0]);
					default: begin
					end
				endcase
			end
			// The result of an item can never come out on the edge that takes
			// it in, so comparing first and predicting second is safe.
			if (result_valid) begin
				if (spike_log.size() == 0) begin
					errors++;
					if (errors <= 10) begin
						$display("%0t: unexpected result neuron=%0d fired=%0b",
							$realtime, fired_neuron, fired);
					end
				end else begin
					exp_r = spike_log.pop_front();
					if (fired_neuron !== exp_r.neuron || fired !== exp_r.spiked) begin
						errors++;
						if (errors <= 10) begin
							$display("%0t: mismatch expected neuron=%0d fired=%0b, got neuron=%0d fired=%0b",
								$realtime, exp_r.neuron, exp_r.spiked, fired_neuron, fired);
						end
					end
				end
			end
			if (start && !busy) begin
				exp_r.neuron = neuron_index;
				exp_r.spiked = neuron_tick(neuron_index, synapse_count, presyn_spikes, random_kick);
				spike_log.push_back(exp_r);
			end
		end
	end

endmodule

FILE: tb/izhikevich_neuron_stdp_update_unit_tb.sv
`timescale 1ns / 100ps

module izhikevich_neuron_stdp_update_unit_tb;

	logic                           clk;
	logic                           arst_n;
	logic                           start;
	logic                           busy;
	logic [izh_pkg::IDX_W-1:0]      neuron_index;
	logic [izh_pkg::CNT_W-1:0]      synapse_count;
	logic [izh_pkg::SPK_W-1:0]      presyn_spikes;
	logic                           random_kick;
	logic                           result_valid;
	logic [izh_pkg::IDX_W-1:0]      fired_neuron;
	logic                           fired;
	logic                           cfg_we;
	logic [izh_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [izh_pkg::CFG_DATA_W-1:0] cfg_data;
	int                             pending;
	int                             errors;

	izhikevich_neuron_stdp_update_unit dut (.*);

	// The checker sees every channel and keeps its own copy of the neuron state.
	izhikevich_neuron_stdp_update_unit_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// The run is bounded by the reset sweep plus about 1200 items and the idle
	// gaps; this allows several times that.
	initial begin
		#6000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Sender pause: mostly none, sometimes a short one, rarely a long one.
	task automatic sender_gap();
		int r;
		int len;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			len = 0;
		end else if (r < 92) begin
			len = $urandom_range(1, 4);
		end else begin
			len = $urandom_range(20, 80);
		end
		if (len > 0) begin
			start <= 1'b0;
			repeat (len) @(posedge clk);
		end
	endtask

	// Presents one item and holds it until the block takes it.
	task automatic send_tick(logic [izh_pkg::IDX_W-1:0] idx, logic [izh_pkg::CNT_W-1:0] cnt,
			logic [izh_pkg::SPK_W-1:0] spk, logic kick);
		neuron_index  <= idx;
		synapse_count <= cnt;
		presyn_spikes <= spk;
		random_kick   <= kick;
		start         <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		sender_gap();
	endtask

	// Registers change only with the block idle and no result outstanding.
	task automatic quiesce();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(logic [izh_pkg::CFG_IDX_W-1:0] idx, int unsigned value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= izh_pkg::CFG_DATA_W'(value);
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic write_all(int unsigned exc, int unsigned ra, int unsigned da,
			int unsigned ri, int unsigned di, int unsigned dep, int unsigned pot,
			int unsigned ceil_w);
		write_reg(izh_pkg::REG_EXC_COUNT, exc);
		write_reg(izh_pkg::REG_RATE_EXC, ra);
		write_reg(izh_pkg::REG_BUMP_EXC, da);
		write_reg(izh_pkg::REG_RATE_INH, ri);
		write_reg(izh_pkg::REG_BUMP_INH, di);
		write_reg(izh_pkg::REG_DEP_GAIN, dep);
		write_reg(izh_pkg::REG_POT_GAIN, pot);
		write_reg(izh_pkg::REG_CEILING, ceil_w);
	endtask

	// Random traffic. Most items hit a pool of twelve neurons around the given
	// boundary index, so that they are driven often enough to spike and learn;
	// the rest go anywhere in the index range with any synapse count.
	task automatic random_phase(int count, int unsigned boundary);
		logic [izh_pkg::IDX_W-1:0] idx;
		logic [izh_pkg::CNT_W-1:0] cnt;
		logic [izh_pkg::SPK_W-1:0] spk;
		int                        r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 75) begin
				idx = izh_pkg::IDX_W'((boundary + $urandom_range(0, 11) + 1018) % 1024);
				cnt = ($urandom_range(0, 3) == 0) ? izh_pkg::CNT_W'($urandom_range(0, 127))
					: izh_pkg::CNT_W'(64);
			end else begin
				idx = izh_pkg::IDX_W'($urandom_range(0, 1023));
				cnt = izh_pkg::CNT_W'($urandom_range(0, 127));
			end
			r = $urandom_range(0, 3);
			if (r == 0) begin
				spk = {$urandom, $urandom};
			end else if (r == 1) begin
				spk = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
			end else if (r == 2) begin
				spk = '1;
			end else begin
				spk = '0;
			end
			send_tick(idx, cnt, spk, 1'($urandom_range(0, 1)));
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		start         = 1'b0;
		neuron_index  = '0;
		synapse_count = '0;
		presyn_spikes = '0;
		random_kick   = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		// The block clears its memories after reset with busy held high.
		@(posedge clk);
		while (busy) @(posedge clk);

		// Directed part at reset settings: field extremes, an oversized synapse
		// count, spike bits above the count, both classes around the boundary,
		// and runs of strong drive on one excitatory and one inhibitory neuron.
		send_tick(10'd0, 7'd0, '0, 1'b0);
		send_tick(10'd1023, 7'd127, '1, 1'b1);
		send_tick(10'd799, 7'd64, '1, 1'b1);
		send_tick(10'd800, 7'd64, '1, 1'b1);
		send_tick(10'd5, 7'd3, 64'hFFFF_FFFF_FFFF_FFF8, 1'b1);
		send_tick(10'd5, 7'd65, 64'h5555_5555_5555_5555, 1'b0);
		for (int i = 0; i < 8; i++) begin
			send_tick(10'd0, 7'd64, '1, 1'b1);
		end
		for (int i = 0; i < 4; i++) begin
			send_tick(10'd1000, 7'd64, '1, 1'b1);
		end
		send_tick(10'd0, 7'd64, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
		quiesce();

		// Everything excitatory; the old inhibitory weights are clamped to zero when STDP updates them.
		write_all(1024, 65535, 4194303, 65535, 4194303, 65535, 65535, 16777215);
		send_tick(10'd1023, 7'd64, '1, 1'b1);
		send_tick(10'd900, 7'd64, '1, 1'b1);
		random_phase(280, 1016);
		quiesce();

		// All inhibitory, every gain and bump zero.
		write_all(0, 0, 0, 0, 0, 0, 0, 0);
		send_tick(10'd0, 7'd64, '1, 1'b1);
		random_phase(250, 6);
		quiesce();

		// Learning with a tight ceiling and an out-of-range class count.
		write_all(2047, 20000, 300000, 3000, 50000, 40000, 50000, 65536);
		random_phase(250, 500);
		quiesce();

		// Back to the reset values, then random settings across each field's range.
		write_all(800, 1311, 524288, 6554, 131072, 7864, 6554, 655360);
		random_phase(200, 800);
		quiesce();
		write_all($urandom_range(0, 1024), $urandom_range(0, 65535),
			$urandom_range(0, 4194303), $urandom_range(0, 65535),
			$urandom_range(0, 4194303), $urandom_range(0, 65535),
			$urandom_range(0, 65535), $urandom_range(0, 16777215));
		random_phase(200, 300);

		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
